[rtl/core/telemetry_frame_byte_stuffer_assert.svh]
// Assertion macros for the telemetry frame byte stuffer checker.
`ifndef TELEMETRY_FRAME_BYTE_STUFFER_ASSERT_SVH
`define TELEMETRY_FRAME_BYTE_STUFFER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TFBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define TFBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

[rtl/core/tfbs_pkg.sv]
// Shared types and constants of the telemetry frame byte stuffer.
`default_nettype none
package tfbs_pkg;
	localparam logic [7:0] FRAME_MARK = 8'h5E;
	localparam logic [7:0] ESC_MARK   = 8'h5D;
	localparam logic [7:0] ESC_FRAME  = 8'h3E;
	localparam logic [7:0] ESC_ESC    = 8'h3D;

	localparam logic [7:0] CV_ID_RESET = 8'd6;
	localparam int unsigned TFBS_QUEUE_DEPTH = 2;

	// Classified frame: id plus two data bytes and their escape flags.
	typedef struct packed {
		logic [7:0] id;
		logic [7:0] lo;
		logic [7:0] hi;
		logic       lo_esc;
		logic       hi_esc;
	} frame_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == FRAME_MARK) || (b == ESC_MARK);
	endfunction
endpackage
`default_nettype wire

[rtl/core/tfbs_front.sv]
// Front end: accepts input items and classifies them into frame descriptors.
`default_nettype none
module tfbs_front
	import tfbs_pkg::*;
(
	input  wire logic        push,
	output logic             full,
	input  wire logic        cmd,
	input  wire logic [7:0]  sensor_id,
	input  wire logic [15:0] value,
	input  wire logic [3:0]  cell_index,
	input  wire logic [11:0] cell_voltage_code,
	input  wire logic [7:0]  cv_id,
	input  wire logic        q_full,
	output logic             wr_en,
	output frame_t           wr_frame
);
	logic [7:0] lo;
	logic [7:0] hi;

	always_comb begin
		if (cmd) begin
			wr_frame.id = cv_id;
			lo = {cell_index, cell_voltage_code[11:8]};
			hi = cell_voltage_code[7:0];
		end else begin
			wr_frame.id = sensor_id;
			lo = value[7:0];
			hi = value[15:8];
		end
		wr_frame.lo     = lo;
		wr_frame.hi     = hi;
		wr_frame.lo_esc = needs_escape(lo);
		wr_frame.hi_esc = needs_escape(hi);
	end

	assign full  = q_full;
	assign wr_en = push && !q_full;
endmodule
`default_nettype wire

[rtl/core/tfbs_queue.sv]
// Short descriptor queue between front and back.
`default_nettype none
module tfbs_queue
	import tfbs_pkg::*;
#(
	parameter int unsigned DEPTH = TFBS_QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire frame_t wr_frame,
	input  wire logic   rd_en,
	output frame_t      rd_frame,
	output logic        q_full,
	output logic        q_empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	frame_t        slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_frame = slot_q[rd_ptr_q];
	assign q_full   = (count_q == CW'(DEPTH));
	assign q_empty  = (count_q == '0);
endmodule
`default_nettype wire

[rtl/core/tfbs_back.sv]
// Back end: walks the head descriptor byte by byte into the output register.
`default_nettype none
module tfbs_back
	import tfbs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire frame_t rd_frame,
	input  wire logic   q_empty,
	output logic        rd_en,
	input  wire logic   pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        last_byte
);
	localparam logic [2:0] ST_SOF = 3'd0;
	localparam logic [2:0] ST_ID  = 3'd1;
	localparam logic [2:0] ST_LO  = 3'd2;
	localparam logic [2:0] ST_LO2 = 3'd3;
	localparam logic [2:0] ST_HI  = 3'd4;
	localparam logic [2:0] ST_HI2 = 3'd5;
	localparam logic [2:0] ST_EOF = 3'd6;

	logic [2:0] step_q;
	logic [2:0] step_nxt;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic [7:0] byte_nxt;
	logic       last_nxt;
	logic       adv;
	logic       emit;

	always_comb begin
		last_nxt = 1'b0;
		unique case (step_q)
			ST_SOF: begin
				byte_nxt = FRAME_MARK;
				step_nxt = ST_ID;
			end
			ST_ID: begin
				byte_nxt = rd_frame.id;
				step_nxt = ST_LO;
			end
			ST_LO: begin
				byte_nxt = rd_frame.lo_esc ? ESC_MARK : rd_frame.lo;
				step_nxt = rd_frame.lo_esc ? ST_LO2 : ST_HI;
			end
			ST_LO2: begin
				byte_nxt = (rd_frame.lo == FRAME_MARK) ? ESC_FRAME : ESC_ESC;
				step_nxt = ST_HI;
			end
			ST_HI: begin
				byte_nxt = rd_frame.hi_esc ? ESC_MARK : rd_frame.hi;
				step_nxt = rd_frame.hi_esc ? ST_HI2 : ST_EOF;
			end
			ST_HI2: begin
				byte_nxt = (rd_frame.hi == FRAME_MARK) ? ESC_FRAME : ESC_ESC;
				step_nxt = ST_EOF;
			end
			ST_EOF: begin
				byte_nxt = FRAME_MARK;
				last_nxt = 1'b1;
				step_nxt = ST_SOF;
			end
			default: begin
				byte_nxt = FRAME_MARK;
				step_nxt = ST_SOF;
			end
		endcase
	end

	assign adv   = !out_valid_q || pop;
	assign emit  = adv && !q_empty;
	assign rd_en = emit && (step_q == ST_EOF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_SOF;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				step_q <= step_nxt;
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_nxt;
			last_q     <= last_nxt;
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;
endmodule
`default_nettype wire

[rtl/core/telemetry_frame_byte_stuffer.sv]
// Top level of the telemetry frame byte stuffer.
// An item pushed into an idle block is written to the queue, then its first byte to the output register.
// The back end gives one output byte per cycle while the queue holds a frame and the
// output slot is free or popped; a frame is 5 to 7 bytes and frames run back to back.
// The queue holds up to QUEUE_DEPTH items, the frame being walked included.
// Reset (arst_n low, async): queue and output empty, cell voltage id back to 6.
`default_nettype none
module telemetry_frame_byte_stuffer
	import tfbs_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = TFBS_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item queue side
	input  wire logic        push,
	output logic             full,
	input  wire logic        cmd,
	input  wire logic [7:0]  sensor_id,
	input  wire logic [15:0] value,
	input  wire logic [3:0]  cell_index,
	input  wire logic [11:0] cell_voltage_code,
	// config write channel (cell voltage sensor id)
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	// result queue side
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last_byte
);
	logic [7:0] cv_id_q;
	logic       wr_en;
	frame_t     wr_frame;
	logic       rd_en;
	frame_t     rd_frame;
	logic       q_full;
	logic       q_empty;

	// Config register: always ready, written on handshake.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_id_q <= CV_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cv_id_q <= cfg_data;
		end
	end

	// Front: pick id/data bytes by cmd, flag bytes that need escaping.
	tfbs_front u_front (
		.push              (push),
		.full              (full),
		.cmd               (cmd),
		.sensor_id         (sensor_id),
		.value             (value),
		.cell_index        (cell_index),
		.cell_voltage_code (cell_voltage_code),
		.cv_id             (cv_id_q),
		.q_full            (q_full),
		.wr_en             (wr_en),
		.wr_frame          (wr_frame)
	);

	// Descriptor queue decouples accept from byte output.
	tfbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_frame (wr_frame),
		.rd_en    (rd_en),
		.rd_frame (rd_frame),
		.q_full   (q_full),
		.q_empty  (q_empty)
	);

	// Back: one byte per cycle into a registered output slot while it is free or popped;
	// head frame is released on its end marker so the next frame starts without a gap.
	tfbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_frame  (rd_frame),
		.q_empty   (q_empty),
		.rd_en     (rd_en),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);
endmodule
`default_nettype wire

[rtl/core/tfbs_checker.sv]
// Port-level checker for the telemetry frame byte stuffer, with its bind.
`default_nettype none
`include "telemetry_frame_byte_stuffer_assert.svh"
module tfbs_checker
	import tfbs_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] out_byte,
	input wire logic       last_byte
);
	// Set when the next result must open a frame.
	logic at_frame_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_frame_start_q <= 1'b1;
		end else if (!empty && pop) begin
			at_frame_start_q <= last_byte;
		end
	end

	`TFBS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_byte) && $stable(last_byte))
	`TFBS_ASSERT_NOW(a_last_is_marker, !empty && last_byte, out_byte == FRAME_MARK)
	`TFBS_ASSERT_NOW(a_frame_opens, !empty && at_frame_start_q, out_byte == FRAME_MARK && !last_byte)
endmodule

bind telemetry_frame_byte_stuffer tfbs_checker u_tfbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.out_byte  (out_byte),
	.last_byte (last_byte)
);
`default_nettype wire
